[rtl/core/mbet_pkg.sv]
// shared constants and tables for the multibrot escape-time core
package mbet_pkg;

  localparam int ZF       = 28;
  localparam int LogF     = 24;
  localparam int CSteps   = 28;

  localparam logic [32:0] KInv = 33'd40752055;

  typedef logic [0:CSteps-1][31:0] atan_tab_t;
  typedef logic [LogF:1][31:0]     root_tab_t;

  localparam atan_tab_t ATAN = {
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    v = x;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // chain of square roots of two, 30 fraction bits
  function automatic root_tab_t make_roots();
    root_tab_t   t;
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int j = 1; j <= LogF; j++) begin
      r = isqrt64(r << 30);
      t[j] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = make_roots();

endpackage

[rtl/core/mbet_div.sv]
// restoring divider for the normalized count, one quotient bit per cycle
module mbet_div
  import mbet_pkg::*;
#(
  parameter int ITER_WIDTH = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ITER_WIDTH-1:0] count_i,
  input  logic [ITER_WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [16:0]           quot_o
);

  localparam int DW = ITER_WIDTH + 16;
  localparam int CW = $clog2(DW + 1);

  logic [ITER_WIDTH-1:0] rem_q, rem_d;
  logic [DW-1:0]         quo_q, quo_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [ITER_WIDTH:0]   trial;
  logic [ITER_WIDTH:0]   diff;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = {count_i, 16'b0};
      cnt_d = CW'(DW);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[ITER_WIDTH-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[ITER_WIDTH-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = (divisor_i == '0) ? 17'd0 : quo_q[16:0];

endmodule

[rtl/core/multibrot_escape_time.sv]
// multibrot escape-time core with real exponent, one shared multiplier
// A point is taken when start is high and busy is low; busy stays high until the
// result beat, which shows on done_o for one cycle and cannot be held off. Each
// iteration of z <- z^p + c runs a sequencer over one 33x33 multiplier and the
// shifters: check and squaring steps, normalize steps (byte steps first), log steps,
// exp steps, vectoring and rotation steps and the steps between them; while z is
// still zero only the check and squaring steps run. After the last check a point
// ends with the final divide.
module multibrot_escape_time
  import mbet_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int ITER_WIDTH  = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] c_re_i,
  input  logic [COORD_WIDTH-1:0] c_im_i,
  output logic                   done_o,
  output logic [ITER_WIDTH-1:0]  iter_count_o,
  output logic [16:0]            norm_value_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int SHR = (COORD_WIDTH >= 32) ? COORD_WIDTH - 32 : 0;
  localparam int SHL = (COORD_WIDTH < 32) ? 32 - COORD_WIDTH : 0;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_SQA  = 4'd2;
  localparam logic [3:0] S_SQB  = 4'd3;
  localparam logic [3:0] S_TST  = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_LOG  = 4'd6;
  localparam logic [3:0] S_MULE = 4'd7;
  localparam logic [3:0] S_EXP  = 4'd8;
  localparam logic [3:0] S_MAG  = 4'd9;
  localparam logic [3:0] S_VEC  = 4'd10;
  localparam logic [3:0] S_PARG = 4'd11;
  localparam logic [3:0] S_KLO  = 4'd12;
  localparam logic [3:0] S_KHI  = 4'd13;
  localparam logic [3:0] S_ROT  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;
  localparam logic [4:0] S_DIVS = 5'd16;
  localparam logic [4:0] S_DIVW = 5'd17;

  localparam logic REG_POWER = 1'b0;
  localparam logic REG_MAXIT = 1'b1;

  logic [4:0]            state_q, state_d;
  logic [14:0]           power_q;
  logic [ITER_WIDTH-1:0] iter_limit_q;
  logic [ITER_WIDTH-1:0] cnt_q, cnt_d;
  logic signed [63:0]    zr_q, zr_d, zi_q, zi_d, cre_q, cre_d, cim_q, cim_d;
  logic [28:0]           ar_q, ar_d, ai_q, ai_d;
  logic [63:0]           r2_q, r2_d;
  logic [63:0]           m_q, m_d;
  logic [5:0]            nn_q, nn_d;
  logic [4:0]            k_q, k_d;
  logic [23:0]           fr_q, fr_d;
  logic signed [39:0]    e_q, e_d;
  logic [31:0]           acc_q, acc_d;
  logic [39:0]           mag_q, mag_d;
  logic signed [63:0]    x_q, x_d, y_q, y_d;
  logic [31:0]           a_q, a_d;
  logic [31:0]           th_q, th_d;
  logic signed [33:0]    s_q, s_d;
  logic [57:0]           pp_q, pp_d;
  logic                  done_q, done_d;
  logic [ITER_WIDTH-1:0] res_cnt_q, res_cnt_d;
  logic [16:0]           res_norm_q, res_norm_d;

  logic signed [32:0]    ma, mb;
  logic signed [65:0]    prod;
  logic signed [63:0]    cre_fix, cim_fix;
  logic signed [63:0]    xs, ys;
  logic [63:0]           abs_r, abs_i;
  logic [8:0]            nd;
  logic [31:0]           mm;
  logic                  aneg;
  logic [32:0]           am;
  logic [31:0]           pr;
  logic signed [15:0]    ei, sh, nsh;
  logic [65:0]           ksum;
  logic signed [63:0]    wr, wi;
  logic                  div_start, div_done;
  logic [16:0]           div_quot;
  logic                  cfg_we;

  assign cre_fix = (64'(signed'(c_re_i)) >>> SHR) <<< SHL;
  assign cim_fix = (64'(signed'(c_im_i)) >>> SHR) <<< SHL;

  assign busy   = (state_q != {1'b0, S_IDLE});
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_POWER: prdata = 32'(power_q);
      REG_MAXIT: prdata = 32'(iter_limit_q);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q      <= 15'd8192;
      iter_limit_q <= ITER_WIDTH'(500);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_POWER: power_q      <= pwdata[14:0];
        REG_MAXIT: iter_limit_q <= pwdata[ITER_WIDTH-1:0];
        default:   ;
      endcase
    end
  end

  // shared multiplier operand select
  assign nd = 9'({3'b0, nn_q}) - 9'd56;
  assign aneg = a_q > 32'h8000_0000;
  assign am = aneg ? (33'h1_0000_0000 - {1'b0, a_q}) : {1'b0, a_q};

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      {1'b0, S_SQA}:  begin ma = {4'b0, ar_q}; mb = {4'b0, ar_q}; end
      {1'b0, S_SQB}:  begin ma = {4'b0, ai_q}; mb = {4'b0, ai_q}; end
      {1'b0, S_LOG}:  begin ma = {2'b0, m_q[30:0]}; mb = {2'b0, m_q[30:0]}; end
      {1'b0, S_MULE}: begin ma = {nd, fr_q}; mb = {18'b0, power_q}; end
      {1'b0, S_EXP}:  begin ma = {1'b0, acc_q}; mb = {1'b0, ROOTS[k_q]}; end
      {1'b0, S_PARG}: begin ma = am; mb = {18'b0, power_q}; end
      {1'b0, S_KLO}:  begin ma = {1'b0, mag_q[31:0]}; mb = KInv; end
      {1'b0, S_KHI}:  begin ma = {25'b0, mag_q[39:32]}; mb = KInv; end
      default:        ;
    endcase
  end

  assign prod = ma * mb;
  assign mm   = prod[61:30];
  assign pr   = prod[43:12];
  assign ksum = {prod[33:0], 32'b0} + {8'b0, pp_q};

  assign xs = x_q >>> k_q;
  assign ys = y_q >>> k_q;

  assign abs_r = zr_q[63] ? 64'(-zr_q) : 64'(zr_q);
  assign abs_i = zi_q[63] ? 64'(-zi_q) : 64'(zi_q);

  assign ei  = 16'(e_q >>> 24);
  assign sh  = ei - 16'sd2;
  assign nsh = -sh;

  always_comb begin
    case (th_q[31:30])
      2'd1:    begin wr = -y_q; wi = x_q;  end
      2'd2:    begin wr = -x_q; wi = -y_q; end
      2'd3:    begin wr = y_q;  wi = -x_q; end
      default: begin wr = x_q;  wi = y_q;  end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    zr_d       = zr_q;
    zi_d       = zi_q;
    cre_d      = cre_q;
    cim_d      = cim_q;
    ar_d       = ar_q;
    ai_d       = ai_q;
    r2_d       = r2_q;
    m_d        = m_q;
    nn_d       = nn_q;
    k_d        = k_q;
    fr_d       = fr_q;
    e_d        = e_q;
    acc_d      = acc_q;
    mag_d      = mag_q;
    x_d        = x_q;
    y_d        = y_q;
    a_d        = a_q;
    th_d       = th_q;
    s_d        = s_q;
    pp_d       = pp_q;
    done_d     = 1'b0;
    res_cnt_d  = res_cnt_q;
    res_norm_d = res_norm_q;
    div_start  = 1'b0;
    case (state_q)
      {1'b0, S_IDLE}: begin
        if (start) begin
          cre_d   = cre_fix;
          cim_d   = cim_fix;
          zr_d    = '0;
          zi_d    = '0;
          cnt_d   = '0;
          state_d = {1'b0, S_CHK};
        end
      end
      {1'b0, S_CHK}: begin
        ar_d = abs_r[28:0];
        ai_d = abs_i[28:0];
        if (cnt_q >= iter_limit_q) state_d = S_DIVS;
        else if (abs_r >= 64'h2000_0000 || abs_i >= 64'h2000_0000) state_d = S_DIVS;
        else state_d = {1'b0, S_SQA};
      end
      {1'b0, S_SQA}: begin
        r2_d    = 64'(prod);
        state_d = {1'b0, S_SQB};
      end
      {1'b0, S_SQB}: begin
        r2_d    = r2_q + 64'(prod);
        state_d = {1'b0, S_TST};
      end
      {1'b0, S_TST}: begin
        if (r2_q >= 64'h0400_0000_0000_0000) begin
          state_d = S_DIVS;
        end else if (r2_q == '0) begin
          zr_d    = cre_q;
          zi_d    = cim_q;
          cnt_d   = cnt_q + 1'b1;
          state_d = {1'b0, S_CHK};
        end else begin
          m_d     = r2_q;
          nn_d    = 6'd57;
          state_d = {1'b0, S_NORM};
        end
      end
      {1'b0, S_NORM}: begin
        if (m_q[57]) begin
          m_d     = {33'b0, m_q[57:27]};
          k_d     = '0;
          fr_d    = '0;
          state_d = {1'b0, S_LOG};
        end else if (m_q[57:50] == '0) begin
          m_d  = m_q << 8;
          nn_d = nn_q - 6'd8;
        end else begin
          m_d  = m_q << 1;
          nn_d = nn_q - 6'd1;
        end
      end
      {1'b0, S_LOG}: begin
        fr_d = {fr_q[22:0], mm[31]};
        m_d  = mm[31] ? {32'b0, 1'b0, mm[31:1]} : {32'b0, mm};
        k_d  = k_q + 1'b1;
        if (k_q == 5'(LogF - 1)) state_d = {1'b0, S_MULE};
      end
      {1'b0, S_MULE}: begin
        e_d     = 40'(prod >>> 13);
        acc_d   = 32'h4000_0000;
        k_d     = 5'd1;
        state_d = {1'b0, S_EXP};
      end
      {1'b0, S_EXP}: begin
        if (e_q[5'(5'(LogF) - k_q)]) acc_d = mm;
        k_d = k_q + 1'b1;
        if (k_q == 5'(LogF)) state_d = {1'b0, S_MAG};
      end
      {1'b0, S_MAG}: begin
        if (sh > 16'sd8) mag_d = {acc_q, 8'b0};
        else if (sh >= 16'sd0) mag_d = 40'(acc_q) << sh[3:0];
        else if (nsh >= 16'sd32) mag_d = '0;
        else mag_d = 40'(acc_q >> nsh[4:0]);
        if (zr_q < 0) begin
          x_d = -zr_q;
          y_d = -zi_q;
          a_d = 32'h8000_0000;
        end else begin
          x_d = zr_q;
          y_d = zi_q;
          a_d = '0;
        end
        k_d     = '0;
        state_d = {1'b0, S_VEC};
      end
      {1'b0, S_VEC}: begin
        if (y_q >= 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          a_d = a_q + ATAN[k_q];
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          a_d = a_q - ATAN[k_q];
        end
        k_d = k_q + 1'b1;
        if (k_q == 5'(CSteps - 1)) state_d = {1'b0, S_PARG};
      end
      {1'b0, S_PARG}: begin
        th_d    = aneg ? (32'd0 - pr) : pr;
        state_d = {1'b0, S_KLO};
      end
      {1'b0, S_KLO}: begin
        pp_d    = prod[57:0];
        state_d = {1'b0, S_KHI};
      end
      {1'b0, S_KHI}: begin
        x_d     = 64'(ksum[65:26]);
        y_d     = '0;
        s_d     = $signed({4'b0, th_q[29:0]});
        k_d     = '0;
        state_d = {1'b0, S_ROT};
      end
      {1'b0, S_ROT}: begin
        if (s_q >= 0) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          s_d = s_q - $signed({2'b0, ATAN[k_q]});
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          s_d = s_q + $signed({2'b0, ATAN[k_q]});
        end
        k_d = k_q + 1'b1;
        if (k_q == 5'(CSteps - 1)) state_d = {1'b0, S_FIN};
      end
      {1'b0, S_FIN}: begin
        zr_d    = wr + cre_q;
        zi_d    = wi + cim_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = {1'b0, S_CHK};
      end
      S_DIVS: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          done_d     = 1'b1;
          res_cnt_d  = cnt_q;
          res_norm_d = div_quot;
          state_d    = {1'b0, S_IDLE};
        end
      end
      default: state_d = {1'b0, S_IDLE};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= {1'b0, S_IDLE};
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    zr_q       <= zr_d;
    zi_q       <= zi_d;
    cre_q      <= cre_d;
    cim_q      <= cim_d;
    ar_q       <= ar_d;
    ai_q       <= ai_d;
    r2_q       <= r2_d;
    m_q        <= m_d;
    nn_q       <= nn_d;
    k_q        <= k_d;
    fr_q       <= fr_d;
    e_q        <= e_d;
    acc_q      <= acc_d;
    mag_q      <= mag_d;
    x_q        <= x_d;
    y_q        <= y_d;
    a_q        <= a_d;
    th_q       <= th_d;
    s_q        <= s_d;
    pp_q       <= pp_d;
    res_cnt_q  <= res_cnt_d;
    res_norm_q <= res_norm_d;
  end

  mbet_div #(
    .ITER_WIDTH(ITER_WIDTH)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .count_i  (cnt_q),
    .divisor_i(iter_limit_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  assign done_o       = done_q;
  assign iter_count_o = res_cnt_q;
  assign norm_value_o = res_norm_q;

endmodule

[bench/multibrot_escape_time_test.sv]
// self-checking testbench for the multibrot escape-time core
`timescale 1ns / 100ps

typedef struct {
  logic [11:0] iter_count;
  logic [16:0] norm_value;
} escape_res_t;

class escape_scoreboard;
  logic [14:0]  power;
  logic [11:0]  iter_limit;
  logic [63:0]  roots[0:24];
  logic [31:0]  atan_turns[0:27];
  escape_res_t  expected_q[$];
  int           n_points;
  int           n_results;
  int           n_errors;

  function new();
    logic [63:0] x;
    logic [63:0] r;
    power      = 15'd8192;
    iter_limit = 12'd500;
    atan_turns = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005};
    roots[0] = 64'h8000_0000;
    for (int j = 1; j <= 24; j++) begin
      x = roots[j-1] << 30;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= x) r = r | (64'd1 << b);
      end
      roots[j] = r;
    end
    n_points  = 0;
    n_results = 0;
    n_errors  = 0;
  endfunction

  // complex power of a nonzero z in polar form
  function void zpow(input longint re, input longint im, input logic [63:0] r2,
                     output longint ore, output longint oim);
    int          n;
    logic [63:0] m;
    logic [63:0] fr;
    logic [63:0] acc;
    logic [63:0] mag;
    logic [63:0] ev;
    logic [63:0] am;
    logic [63:0] prod;
    longint      l2;
    longint      e;
    longint      ei;
    longint      sh;
    longint      x;
    longint      y;
    longint      nx;
    longint      s;
    logic [31:0] a;
    logic [31:0] th;
    logic        neg;
    n = 63;
    while (n > 0 && r2[n] == 1'b0) n--;
    m  = (n > 30) ? (r2 >> (n - 30)) : (r2 << (30 - n));
    fr = '0;
    for (int k = 0; k < 24; k++) begin
      m  = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        fr = fr | 64'd1;
        m  = m >> 1;
      end
    end
    l2 = longint'(n - 56) * (longint'(1) << 24) + longint'(fr);
    e  = (l2 * longint'({49'd0, power})) >>> 13;
    ei = e >>> 24;
    ev = e;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 24; k++) begin
      if (ev[24-k]) acc = (acc * roots[k]) >> 30;
    end
    sh = ei - 2;
    if (sh > 8) sh = 8;
    if (sh >= 0) mag = acc << sh;
    else if (-sh >= 63) mag = '0;
    else mag = acc >> (-sh);

    x = re;
    y = im;
    a = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = 32'h8000_0000;
    end
    for (int k = 0; k < 28; k++) begin
      if (y >= 0) begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        a  = a + atan_turns[k];
      end else begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        a  = a - atan_turns[k];
      end
      x = nx;
    end

    neg  = a > 32'h8000_0000;
    am   = neg ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
    prod = (am * {49'd0, power}) >> 12;
    th   = neg ? (32'd0 - prod[31:0]) : prod[31:0];

    s = longint'({34'd0, th[29:0]});
    x = longint'((mag * 64'd40752055) >> 26);
    y = 0;
    for (int k = 0; k < 28; k++) begin
      if (s >= 0) begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        s  = s - longint'({32'd0, atan_turns[k]});
      end else begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        s  = s + longint'({32'd0, atan_turns[k]});
      end
      x = nx;
    end
    case (th[31:30])
      2'd1: begin ore = -y; oim = x;  end
      2'd2: begin ore = -x; oim = -y; end
      2'd3: begin ore = y;  oim = -x; end
      default: begin ore = x; oim = y; end
    endcase
  endfunction

  function escape_res_t escape_count(input logic [31:0] c_re, input logic [31:0] c_im);
    escape_res_t res;
    longint      cre;
    longint      cim;
    longint      zr;
    longint      zi;
    longint      wr;
    longint      wi;
    logic [63:0] ar;
    logic [63:0] ai;
    logic [63:0] r2;
    logic [63:0] q;
    int          cnt;
    cre = longint'($signed(c_re));
    cim = longint'($signed(c_im));
    zr  = 0;
    zi  = 0;
    cnt = 0;
    while (cnt < iter_limit) begin
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      if (ar >= (64'd1 << 29) || ai >= (64'd1 << 29)) break;
      r2 = ar * ar + ai * ai;
      if (r2 >= (64'd1 << 58)) break;
      if (r2 == 0) begin
        wr = 0;
        wi = 0;
      end else begin
        zpow(zr, zi, r2, wr, wi);
      end
      zr = wr + cre;
      zi = wi + cim;
      cnt++;
    end
    res.iter_count = cnt[11:0];
    if (iter_limit == 0) begin
      res.norm_value = '0;
    end else begin
      q = (64'(cnt) << 16) / {52'd0, iter_limit};
      res.norm_value = q[16:0];
    end
    return res;
  endfunction

  function void note_point(input logic [31:0] c_re, input logic [31:0] c_im);
    expected_q = {expected_q, escape_count(c_re, c_im)};
    n_points++;
  endfunction

  function void check_result(input logic [11:0] iter_count, input logic [16:0] norm_value);
    escape_res_t exp_r;
    n_results++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result beat iter_count=%0d norm_value=%0d",
               $time, iter_count, norm_value);
      n_errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (iter_count !== exp_r.iter_count) begin
      $display("%0t: iter_count expected %0d actual %0d", $time, exp_r.iter_count, iter_count);
      n_errors++;
    end
    if (norm_value !== exp_r.norm_value) begin
      $display("%0t: norm_value expected %0d actual %0d", $time, exp_r.norm_value, norm_value);
      n_errors++;
    end
  endfunction
endclass

module multibrot_escape_time_test;
  localparam int CycleLimit = 6000000;
  localparam logic [2:0] AddrPower   = 3'd0;
  localparam logic [2:0] AddrMaxIter = 3'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] c_re_i = '0;
  logic [31:0] c_im_i = '0;
  logic        done_o;
  logic [11:0] iter_count_o;
  logic [16:0] norm_value_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  escape_scoreboard sb = new();
  int cycles = 0;
  int n_phases = 0;

  multibrot_escape_time u_top (
    .clk_i, .rst_ni, .start, .busy, .c_re_i, .c_im_i, .done_o, .iter_count_o,
    .norm_value_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(iter_count_o, norm_value_o);
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrPower) sb.power = data[14:0];
    else if (addr == AddrMaxIter) sb.iter_limit = data[11:0];
  endtask

  task automatic set_mode(input int pw, input int mi);
    if (start) begin
      @(posedge clk_i);
      start <= 1'b0;
    end
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    reg_write(AddrPower, pw);
    reg_write(AddrMaxIter, mi);
    n_phases++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_point(input logic [31:0] re, input logic [31:0] im);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    c_re_i <= re;
    c_im_i <= im;
    do @(posedge clk_i); while (busy);
    sb.note_point(re, im);
  endtask

  function automatic logic [31:0] near_point();
    logic [31:0] v;
    v = $urandom;
    return {{3{v[31]}}, v[28:0]};
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // squaring with a small limit: zero, negative axis, boundary points
    set_mode(8192, 20);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'hF000_0000, 32'h0000_0000);
    send_point(32'hE000_0000, 32'h0000_0000);
    send_point(32'h0400_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h1000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hF400_0000, 32'h0199_9999);
    // largest exponent, tiny point underflows
    set_mode(32767, 16);
    send_point(32'h0000_0001, 32'h0000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'hF800_0000, 32'h0000_0000);
    send_point(32'h0800_0000, 32'h0800_0000);
    // unit exponent
    set_mode(4096, 12);
    send_point(32'h0100_0000, 32'h0200_0000);
    send_point(32'hFC00_0000, 32'h0000_0000);
    send_point(32'h0000_0000, 32'h0000_0000);
    // single iteration reaches the top of the normalized range
    set_mode(12000, 1);
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // largest limit with points that escape at once
    set_mode(8192, 4095);
    send_point(32'h2800_0000, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_0000, 32'hD000_0000);
    // no iteration at all
    set_mode(20000, 0);
    send_point(32'h0100_0000, 32'h0100_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_mode(4096, $urandom_range(1, 30));
        1: set_mode(32767, $urandom_range(1, 30));
        default: set_mode($urandom_range(4096, 32767), $urandom_range(1, 30));
      endcase
      for (int i = 0; i < 21; i++) begin
        if ($urandom_range(99) < 80) send_point(near_point(), near_point());
        else send_point($urandom, $urandom);
      end
    end

    @(posedge clk_i);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d points over %0d register settings, %0d results checked",
             sb.n_points, n_phases, sb.n_results);
    $display("exponents from 1 to nearly 8, limits from 0 to 4095, %0d mismatches",
             sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
